[src/assert_macros.svh]
// Assertion macros shared by the oscillator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/fpas_pkg.sv]
// Package: word types, table geometry and quarter-wave sine contents.
package fpas_pkg;

  localparam int TABLE_ADDR_BITS = 10;
  localparam int TBL_SIZE        = 1 << TABLE_ADDR_BITS;
  localparam int SINE_W          = 15;

  localparam logic [31:0] SCALE_RESET = 32'd24932236;
  localparam logic [15:0] FULL_SCALE  = 16'd32767;

  // Input word: one frequency sample.
  typedef struct packed {
    logic signed [23:0] freq_hz;
    logic               start_of_note;
    logic               last_of_note;
  } in_word_t;

  // Output word: one sine sample.
  typedef struct packed {
    logic signed [15:0] sine_value;
    logic               last_sample;
  } out_word_t;

  // Table lookup request from the phase stage.
  typedef struct packed {
    logic [TABLE_ADDR_BITS-1:0] addr;
    logic                       neg;   // lower half of the turn
    logic                       full;  // peak of the wave, not in the table
    logic                       last;
  } lut_req_t;

  typedef logic [TBL_SIZE-1:0][SINE_W-1:0] quarter_rom_t;

  // One table entry: Taylor series of sin in Q30, scaled to 32767.
  function automatic logic [SINE_W-1:0] sine_entry(int unsigned k);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] v;
    longint      sum;
    x   = (64'd1686629713 * 64'(k)) >> TABLE_ADDR_BITS;
    t   = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) sum = sum - longint'(t);
      else              sum = sum + longint'(t);
    end
    if (sum <= 0) return '0;
    v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return v[SINE_W-1:0];
  endfunction

  function automatic quarter_rom_t build_quarter_rom();
    quarter_rom_t rom;
    for (int k = 0; k < TBL_SIZE; k++) rom[k] = sine_entry(k);
    return rom;
  endfunction

  localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();

endpackage

[src/fpas_ram.sv]
// Generic simple dual-port RAM with registered read.
module fpas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[src/fpas_phase_acc.sv]
// Phase stage: step multiply, phase accumulator and table address fold.
module fpas_phase_acc import fpas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        accept,
  input  in_word_t    in_word,
  input  logic        adv,
  output logic        req_valid,
  output lut_req_t    req
);
  `include "assert_macros.svh"

  localparam int AW = TABLE_ADDR_BITS;

  logic [31:0]        scale_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic [31:0]        step_r, step_nxt;
  logic               start_r, last_r;
  logic [31:0]        acc_r, acc_nxt;
  logic signed [56:0] prod;
  logic [31:0]        phase_cur;
  logic [AW-1:0]      idx;

  // Phase step per hertz register
  always_ff @(posedge clk) begin
    if (!rst_n) scale_r <= SCALE_RESET;
    else if (cfg_we) scale_r <= cfg_wdata;
  end

  // Step = floor(freq * scale / 2^16), taken mod 2^32
  assign prod     = $signed(in_word.freq_hz) * $signed({1'b0, scale_r});
  assign step_nxt = prod[47:16];

  assign s1_valid_nxt = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step_r  <= step_nxt;
      start_r <= in_word.start_of_note;
      last_r  <= in_word.last_of_note;
    end
  end

  // Accumulate when the word moves on to the lookup
  assign phase_cur = start_r ? 32'd0 : acc_r;
  assign acc_nxt   = (s1_valid_r && adv) ? (phase_cur + step_r) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) acc_r <= '0;
    else        acc_r <= acc_nxt;
  end

  // Quadrant fold: odd quadrants read the table mirrored
  assign idx       = phase_cur[29 -: AW];
  assign req_valid = s1_valid_r;
  assign req.addr  = phase_cur[30] ? ({AW{1'b0}} - idx) : idx;
  assign req.full  = phase_cur[30] && (idx == '0);
  assign req.neg   = phase_cur[31];
  assign req.last  = last_r;

  `ASSERT_NEXT(a_start_clears_phase, s1_valid_r && start_r && adv, acc_r == $past(step_r))
  `ASSERT_IMPL(a_hold_when_blocked, s1_valid_r && !adv && !accept, s1_valid_nxt)

endmodule

[src/fpas_sine_lookup.sv]
// Sine stage: table load after reset, table RAM, sign and output register.
module fpas_sine_lookup import fpas_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  input  lut_req_t  req,
  output logic      ready,
  output logic      loading,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);
  `include "assert_macros.svh"

  localparam int AW = TABLE_ADDR_BITS;
  localparam logic [AW-1:0] ADDR_MAX = '1;

  logic              loading_r;
  logic [AW-1:0]     load_cnt_r;
  logic [SINE_W-1:0] rd_data;
  logic              v2_r, neg2_r, full2_r, last2_r;
  logic              out_adv;
  logic [15:0]       mag;
  logic [15:0]       sine_nxt;
  logic              out_valid_r;
  out_word_t         out_word_r;

  // Table load sweep, one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r  <= 1'b1;
      load_cnt_r <= '0;
    end else if (loading_r) begin
      load_cnt_r <= load_cnt_r + 1'b1;
      if (load_cnt_r == ADDR_MAX) loading_r <= 1'b0;
    end
  end

  assign loading = loading_r;

  // Stage handshake: move on when the next register is free or draining
  assign out_adv = !out_valid_r || !out_stall;
  assign ready   = !v2_r || out_adv;

  fpas_ram #(
    .WIDTH(SINE_W),
    .DEPTH(TBL_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (loading_r),
    .waddr (load_cnt_r),
    .wdata (QUARTER_ROM[load_cnt_r]),
    .re    (ready),
    .raddr (req.addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n)     v2_r <= 1'b0;
    else if (ready) v2_r <= req_valid;
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      neg2_r  <= req.neg;
      full2_r <= req.full;
      last2_r <= req.last;
    end
  end

  // Magnitude and sign
  assign mag      = full2_r ? FULL_SCALE : {1'b0, rd_data};
  assign sine_nxt = neg2_r ? (16'd0 - mag) : mag;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n)       out_valid_r <= 1'b0;
    else if (out_adv) out_valid_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_word_r.sine_value <= $signed(sine_nxt);
      out_word_r.last_sample <= last2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `ASSERT_IMPL(a_no_lookup_during_load, loading_r, !req_valid)
  `ASSERT_NEXT(a_read_data_held, v2_r && !ready, $stable(rd_data))
  `ASSERT_IMPL(a_peak_at_zero_index, req_valid && req.full, req.addr == '0)

endmodule

[src/fm_phase_accumulator_sine.sv]
// Numerically controlled oscillator, top level.
//
// Input channel (in_valid / in_stall / in_word): one frequency sample per word,
// signed Q15.8 hertz, with start and last flags. A word is taken at a clock
// edge with in_valid high and in_stall low. start_of_note zeroes the phase
// before this word's sine is formed; last_of_note is copied to last_sample.
// Output channel (out_valid / out_stall / out_word): one signed Q1.15 sine per
// input word, in order. The phase then advances by freq * scale / 2^16.
// cfg_we / cfg_wdata write the phase step per hertz; write only while idle.
// Each word passes the phase-stage register, the table read and the output
// register in turn. Throughput: one word per cycle while no stall backs up
// the pipe and the table is loaded, set by the phase add loop.
// Reset (rst_n low, synchronous) zeroes the phase, restores the scale and
// starts a load of all 1024 entries of the quarter-wave table RAM;
// in_stall stays high until that load is done.
// A stalled output holds its word; the two inner stages keep filling, so
// outside the table load, input is stalled only once every stage holds a word.
module fm_phase_accumulator_sine import fpas_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);

  logic     accept;
  logic     req_valid;
  lut_req_t req;
  logic     lut_ready;
  logic     loading;

  // Input side stalls while loading or when the phase stage cannot move
  assign in_stall = loading || (req_valid && !lut_ready);
  assign accept   = in_valid && !in_stall;

  fpas_phase_acc u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_word   (in_word),
    .adv       (lut_ready),
    .req_valid (req_valid),
    .req       (req)
  );

  fpas_sine_lookup u_sine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .ready     (lut_ready),
    .loading   (loading),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
